[design/bfr_pkg.sv]
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants for the byte stream field reader: item
// structs, field kinds, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bfr_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STREAM_SIZE = 2'd0,
    REG_FIELD_MODE  = 2'd1
  } cfg_reg_e;

  // Field kinds selected by field_mode
  typedef enum logic [2:0] {
    MODE_VARINT = 3'd0,
    MODE_U8     = 3'd1,
    MODE_U16    = 3'd2,
    MODE_U32    = 3'd3,
    MODE_U64    = 3'd4
  } field_mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_PAST_END = 2'd2
  } status_e;

  // Varint byte layout
  localparam logic [7:0] GroupMask = 8'h7F;
  localparam int unsigned MoreBit  = 7;

  // Largest byte count a result can report
  localparam logic [3:0] MaxByteCount = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] field_value;
    logic [3:0]  byte_count;
    status_e     status;
  } out_item_t;

endpackage

[design/bfr_step.sv]
// ----------------------------------------------------------------------------
// bfr_step
// One step of the field reader: from the current parse state and one
// input byte, work out the next state and the result item, if any.
// ----------------------------------------------------------------------------
module bfr_step #(
  parameter int unsigned OFFSET_BITS   = 32,
  parameter int unsigned MAX_MULTIBYTE = 10
) (
  input  bfr_pkg::in_item_t    item_i,
  input  logic [31:0]          stream_size_i,
  input  logic [2:0]           field_mode_i,
  input  logic [OFFSET_BITS-1:0] read_offset_i,
  input  logic [63:0]          acc_i,
  input  logic [3:0]           field_bytes_i,
  input  logic                 halted_i,
  output logic [OFFSET_BITS-1:0] read_offset_o,
  output logic [63:0]          acc_o,
  output logic [3:0]           field_bytes_o,
  output logic                 halted_o,
  output logic                 emit_o,
  output bfr_pkg::out_item_t   result_o
);

  // Compare width: holds offset plus a few bytes, and the stream size
  localparam int unsigned CmpW = (OFFSET_BITS + 1 > 33) ? OFFSET_BITS + 1 : 33;

  logic [OFFSET_BITS-1:0] ro;
  logic [63:0]            acc;
  logic [3:0]             fb;
  logic                   halt;
  logic [3:0]             taken;
  logic [3:0]             width;
  logic [3:0]             need;
  logic [CmpW-1:0]        size_ext;
  logic [CmpW-1:0]        sum_fb;
  logic [CmpW-1:0]        sum_taken;
  logic [CmpW-1:0]        sum_need;
  logic [63:0]            acc_vi;
  logic [63:0]            acc_fx;
  logic [63:0]            fx_value;
  logic                   is_varint;

  // Stream start clears the state before the byte is looked at
  assign ro   = item_i.stream_start ? '0 : read_offset_i;
  assign acc  = item_i.stream_start ? '0 : acc_i;
  assign fb   = item_i.stream_start ? '0 : field_bytes_i;
  assign halt = item_i.stream_start ? 1'b0 : halted_i;

  assign taken     = fb + 4'd1;
  assign is_varint = (field_mode_i == bfr_pkg::MODE_VARINT);

  // Fixed field width in bytes; unused codes read as 64 bit
  always_comb begin
    unique case (field_mode_i)
      bfr_pkg::MODE_U8:  width = 4'd1;
      bfr_pkg::MODE_U16: width = 4'd2;
      bfr_pkg::MODE_U32: width = 4'd4;
      default:           width = 4'd8;
    endcase
  end

  assign need = (taken > width) ? taken : width;

  // End of stream checks
  assign size_ext  = CmpW'(stream_size_i);
  assign sum_fb    = CmpW'(ro) + CmpW'(fb);
  assign sum_taken = CmpW'(ro) + CmpW'(taken);
  assign sum_need  = CmpW'(ro) + CmpW'(need);

  // Shift in the new group or byte
  assign acc_vi = {acc[56:0], item_i.data_byte[6:0] & bfr_pkg::GroupMask[6:0]};
  assign acc_fx = {acc[55:0], item_i.data_byte};

  // Mask the fixed field to its width
  always_comb begin
    unique case (width)
      4'd1:    fx_value = {56'd0, acc_fx[7:0]};
      4'd2:    fx_value = {48'd0, acc_fx[15:0]};
      4'd4:    fx_value = {32'd0, acc_fx[31:0]};
      default: fx_value = acc_fx;
    endcase
  end

  // Decide the outcome of this byte
  always_comb begin
    read_offset_o       = ro;
    acc_o               = acc;
    field_bytes_o       = fb;
    halted_o            = halt;
    emit_o              = 1'b0;
    result_o.field_value = '0;
    result_o.byte_count  = taken;
    result_o.status      = bfr_pkg::STATUS_OK;

    if (!halt) begin
      acc_o         = is_varint ? acc_vi : acc_fx;
      field_bytes_o = taken;
      if (is_varint) begin
        priority if (sum_fb >= size_ext) begin
          emit_o          = 1'b1;
          result_o.status = bfr_pkg::STATUS_PAST_END;
        end else if (!item_i.data_byte[bfr_pkg::MoreBit]) begin
          emit_o               = 1'b1;
          result_o.field_value = acc_vi;
        end else if (taken >= 4'(MAX_MULTIBYTE)) begin
          emit_o          = 1'b1;
          result_o.status = bfr_pkg::STATUS_TOO_LONG;
        end else if (sum_taken >= size_ext) begin
          emit_o          = 1'b1;
          result_o.status = bfr_pkg::STATUS_PAST_END;
        end else begin
          emit_o = 1'b0;
        end
      end else begin
        priority if (sum_need > size_ext) begin
          emit_o          = 1'b1;
          result_o.status = bfr_pkg::STATUS_PAST_END;
        end else if (taken >= width) begin
          emit_o               = 1'b1;
          result_o.field_value = fx_value;
        end else begin
          emit_o = 1'b0;
        end
      end

      // Close the field: advance on success, halt on error
      if (emit_o) begin
        acc_o         = '0;
        field_bytes_o = '0;
        if (result_o.status == bfr_pkg::STATUS_OK) begin
          read_offset_o = ro + OFFSET_BITS'(taken);
        end else begin
          halted_o = 1'b1;
        end
      end
    end
  end

endmodule

[design/bytestream_field_reader_top.sv]
// ----------------------------------------------------------------------------
// bytestream_field_reader_top
// Cuts a byte stream into varint or big-endian fixed fields, tracking the
// read offset against the configured stream size and flagging errors.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------
//   in       | input     | in_valid_i / in_ready_o   | in_item_i (byte, start)
//   out      | output    | out_valid_o / out_ready_i | out_item_o (value, count, status)
//   cfg      | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle; its result, if any, shows in the output
// register the next cycle. The parse state updates in the accept cycle.
// The input stalls only while a result is held and out_ready_i is low.
// Reset clears the parse state and loads stream_size 1, field_mode varint.
// ----------------------------------------------------------------------------
module bytestream_field_reader_top #(
  parameter int unsigned OFFSET_BITS   = 32,
  parameter int unsigned MAX_MULTIBYTE = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bfr_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bfr_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [bfr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bfr_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  logic [31:0]            stream_size_q;
  logic [2:0]             field_mode_q;
  logic [OFFSET_BITS-1:0] read_offset_q, read_offset_d;
  logic [63:0]            acc_q, acc_d;
  logic [3:0]             field_bytes_q, field_bytes_d;
  logic                   halted_q, halted_d;
  logic                   out_valid_q;
  bfr_pkg::out_item_t     out_item_q;
  bfr_pkg::out_item_t     result;
  logic                   emit;
  logic                   in_fire;

  // Take a byte whenever the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_size_q <= 32'd1;
      field_mode_q  <= bfr_pkg::MODE_VARINT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfr_pkg::REG_STREAM_SIZE: stream_size_q <= cfg_wdata_i[31:0];
        bfr_pkg::REG_FIELD_MODE:  field_mode_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  bfr_step #(
    .OFFSET_BITS  (OFFSET_BITS),
    .MAX_MULTIBYTE(MAX_MULTIBYTE)
  ) u_step (
    .item_i       (in_item_i),
    .stream_size_i(stream_size_q),
    .field_mode_i (field_mode_q),
    .read_offset_i(read_offset_q),
    .acc_i        (acc_q),
    .field_bytes_i(field_bytes_q),
    .halted_i     (halted_q),
    .read_offset_o(read_offset_d),
    .acc_o        (acc_d),
    .field_bytes_o(field_bytes_d),
    .halted_o     (halted_d),
    .emit_o       (emit),
    .result_o     (result)
  );

  // Parse state advances on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_offset_q <= '0;
      acc_q         <= '0;
      field_bytes_q <= '0;
      halted_q      <= 1'b0;
    end else if (in_fire) begin
      read_offset_q <= read_offset_d;
      acc_q         <= acc_d;
      field_bytes_q <= field_bytes_d;
      halted_q      <= halted_d;
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[design/bfr_checker.sv]
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks for the field reader, attached to the top level.
// ----------------------------------------------------------------------------
module bfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input bfr_pkg::out_item_t           out_item_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Stall input while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result blocked");

  // Error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != bfr_pkg::STATUS_OK |->
      out_item_o.field_value == 64'd0)
    else $error("error result with nonzero value");

  // Byte count and status stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.byte_count != 4'd0 &&
      out_item_o.byte_count <= bfr_pkg::MaxByteCount &&
      (out_item_o.status == bfr_pkg::STATUS_OK ||
       out_item_o.status == bfr_pkg::STATUS_TOO_LONG ||
       out_item_o.status == bfr_pkg::STATUS_PAST_END))
    else $error("result count or status out of range");

endmodule

bind bytestream_field_reader_top bfr_checker u_bfr_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte stream field reader. A queue of bytes
// feeds a bursty valid/ready driver; each accepted byte runs through a
// local field decoder whose results are queued and compared field by field
// against what the monitor collects from the output channel under a
// stalling receiver. Stream size and field kind change between phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned OffsetBits     = 32;
  localparam int unsigned VarintMaxBytes = 10;
  localparam int unsigned RandomItems    = 800;
  localparam int unsigned PhaseItems     = 60;
  localparam int unsigned LongHold       = 400;
  localparam int unsigned IdleLimit      = 4000;

  logic                         clk_i     = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready_o;
  bfr_pkg::in_item_t            in_item   = '0;
  logic                         out_valid_o;
  logic                         out_ready = 1'b0;
  bfr_pkg::out_item_t           out_item_o;
  logic                         cfg_we    = 1'b0;
  logic [bfr_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [bfr_pkg::CfgDataW-1:0] cfg_wdata = '0;

  // Decoder copy: configuration and parse state
  logic [31:0] cfg_size = 32'd1;
  logic [2:0]  cfg_mode = bfr_pkg::MODE_VARINT;
  logic [31:0] rd_offset = '0;
  logic [63:0] field_acc = '0;
  logic [3:0]  field_len = '0;
  bit          stream_halted = 1'b0;

  bfr_pkg::in_item_t  pending_bytes[$];
  bfr_pkg::out_item_t expected_fields[$];
  bfr_pkg::out_item_t want_item;

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 1;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  logic [9:0]  rx_tick        = '0;
  logic        long_hold_req  = 1'b0;
  logic        hold_started   = 1'b0;

  bytestream_field_reader_top #(
    .OFFSET_BITS  (OffsetBits),
    .MAX_MULTIBYTE(VarintMaxBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the decoder by one accepted byte; queue the field it completes
  function automatic void predict_field(bfr_pkg::in_item_t it);
    logic [63:0]        size64;
    logic [63:0]        base;
    logic [63:0]        taken;
    logic [63:0]        width;
    logic [63:0]        need;
    bfr_pkg::out_item_t res;
    bit                 done;
    if (it.stream_start) begin
      rd_offset     = '0;
      stream_halted = 1'b0;
      field_acc     = '0;
      field_len     = '0;
    end
    if (stream_halted) return;
    size64 = {32'b0, cfg_size};
    base   = {32'b0, rd_offset};
    taken  = {60'b0, field_len} + 64'd1;
    res    = '0;
    done   = 1'b0;
    if (cfg_mode == bfr_pkg::MODE_VARINT) begin
      if (base + {60'b0, field_len} >= size64) begin
        res.status = bfr_pkg::STATUS_PAST_END;
        done       = 1'b1;
      end else begin
        field_acc = {field_acc[56:0], it.data_byte[6:0]};
        field_len = taken[3:0];
        if (!it.data_byte[bfr_pkg::MoreBit]) begin
          res.field_value = field_acc;
          res.status      = bfr_pkg::STATUS_OK;
          done            = 1'b1;
        end else if (taken >= VarintMaxBytes) begin
          res.status = bfr_pkg::STATUS_TOO_LONG;
          done       = 1'b1;
        end else if (base + taken >= size64) begin
          res.status = bfr_pkg::STATUS_PAST_END;
          done       = 1'b1;
        end
      end
    end else begin
      case (cfg_mode)
        bfr_pkg::MODE_U8:  width = 64'd1;
        bfr_pkg::MODE_U16: width = 64'd2;
        bfr_pkg::MODE_U32: width = 64'd4;
        default:           width = 64'd8;
      endcase
      need = (taken > width) ? taken : width;
      if (base + need > size64) begin
        res.status = bfr_pkg::STATUS_PAST_END;
        done       = 1'b1;
      end else begin
        field_acc = {field_acc[55:0], it.data_byte};
        field_len = taken[3:0];
        if (taken >= width) begin
          res.field_value = (width < 64'd8) ?
                            (field_acc & ((64'd1 << (width * 8)) - 64'd1)) : field_acc;
          res.status      = bfr_pkg::STATUS_OK;
          done            = 1'b1;
        end
      end
    end
    if (done) begin
      res.byte_count = taken[3:0];
      if (res.status != bfr_pkg::STATUS_OK) stream_halted = 1'b1;
      else rd_offset = rd_offset + {28'b0, res.byte_count};
      field_acc = '0;
      field_len = '0;
      expected_fields.push_back(res);
    end
  endfunction

  // Driver: offer queued bytes in bursts separated by random gaps
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_item    <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready_o) predict_field(in_item);
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_bytes.size() != 0) begin
          in_item  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotate through stall patterns, with one long hold on request
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rx_tick      <= '0;
      hold_left    <= 0;
      hold_started <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (long_hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_left    <= LongHold;
        out_ready    <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (rx_tick[8:7])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= 1'($urandom_range(0, 1));
          2'd2:    out_ready <= (rx_tick[1:0] != 2'd0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expected field
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_fields.size() == 0) begin
        if (mismatch_count < 10)
          $display("mismatch: unexpected result value=%h count=%0d status=%0d",
                   out_item_o.field_value, out_item_o.byte_count, out_item_o.status);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want_item = expected_fields.pop_front();
        if (out_item_o.field_value !== want_item.field_value ||
            out_item_o.byte_count !== want_item.byte_count ||
            out_item_o.status !== want_item.status) begin
          if (mismatch_count < 10)
            $display("mismatch: expected value=%h count=%0d status=%0d, got %h %0d %0d",
                     want_item.field_value, want_item.byte_count, want_item.status,
                     out_item_o.field_value, out_item_o.byte_count, out_item_o.status);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic start);
    bfr_pkg::in_item_t it;
    it.data_byte    = b;
    it.stream_start = start;
    pending_bytes.push_back(it);
  endtask

  // Hold until every byte is taken and every result has come, then settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || expected_fields.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input bfr_pkg::cfg_reg_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == bfr_pkg::REG_STREAM_SIZE) cfg_size = data;
    else if (idx == bfr_pkg::REG_FIELD_MODE) cfg_mode = data[2:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_mode(input logic [2:0] mode);
    logic [31:0] data;
    data      = $urandom();
    data[2:0] = mode;
    cfg_write(bfr_pkg::REG_FIELD_MODE, data);
  endtask

  // Queue one stream of mostly well-formed fields, with some noise bytes
  task automatic queue_stream(output int unsigned count);
    int unsigned span;
    int unsigned limit;
    int unsigned len;
    int unsigned width;
    logic [7:0]  b;
    span  = (cfg_size > 32'd48) ? 48 : cfg_size;
    limit = span + $urandom_range(0, 3);
    if (limit == 0) limit = 1;
    count = 0;
    while (count < limit) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_byte(8'($urandom()), (count == 0) || ($urandom_range(0, 3) == 0));
        count++;
      end else if (cfg_mode == bfr_pkg::MODE_VARINT) begin
        len = ($urandom_range(0, 15) == 0) ? VarintMaxBytes + 1 :
              $urandom_range(1, $urandom_range(1, VarintMaxBytes));
        for (int unsigned i = 0; i < len; i++) begin
          b     = 8'($urandom());
          b[7]  = (i != len - 1);
          queue_byte(b, count == 0);
          count++;
        end
      end else begin
        case (cfg_mode)
          bfr_pkg::MODE_U8:  width = 1;
          bfr_pkg::MODE_U16: width = 2;
          bfr_pkg::MODE_U32: width = 4;
          default:           width = 8;
        endcase
        for (int unsigned i = 0; i < width; i++) begin
          queue_byte(8'($urandom()), count == 0);
          count++;
        end
      end
    end
  endtask

  initial begin
    int unsigned random_total;
    int unsigned phase_total;
    int unsigned added;
    int unsigned phase;
    logic [31:0] size;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset settings: one-byte stream, varint fields
    queue_byte(8'h7F, 1'b1);   // ends in one byte
    queue_byte(8'h00, 1'b0);   // byte past the end of the stream
    queue_byte(8'h80, 1'b1);   // varint not ended at the last byte
    queue_byte(8'h55, 1'b0);   // ignored while halted
    wait_idle();

    // Overlong varint
    cfg_write(bfr_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
    for (int i = 0; i < VarintMaxBytes; i++) queue_byte(8'hFF, i == 0);
    wait_idle();

    // Meaningless mode acts as a 64-bit word, which overruns a 4-byte stream
    cfg_write(bfr_pkg::REG_STREAM_SIZE, 32'd4);
    write_mode(3'd7);
    queue_byte(8'h12, 1'b1);
    wait_idle();

    // Empty stream
    cfg_write(bfr_pkg::REG_STREAM_SIZE, 32'd0);
    write_mode(bfr_pkg::MODE_U16);
    queue_byte(8'h00, 1'b1);
    wait_idle();

    // Switch from 32-bit to 8-bit words in the middle of a field
    cfg_write(bfr_pkg::REG_STREAM_SIZE, 32'd100);
    write_mode(bfr_pkg::MODE_U32);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'h34, 1'b0);
    wait_idle();
    write_mode(bfr_pkg::MODE_U8);
    queue_byte(8'hFF, 1'b0);
    wait_idle();

    // Random phases, each with its own stream size and field kind
    random_total = 0;
    phase        = 0;
    while (random_total < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       size = 32'd0;
        1:       size = 32'd1;
        2:       size = 32'hFFFF_FFFF;
        3:       size = $urandom_range(2, 8);
        default: size = $urandom_range(2, 40);
      endcase
      cfg_write(bfr_pkg::REG_STREAM_SIZE, size);
      write_mode(3'(phase % 8));
      if (phase == 3) begin
        @(posedge clk_i);
        long_hold_req <= 1'b1;
      end
      phase_total = 0;
      while (phase_total < PhaseItems) begin
        queue_stream(added);
        phase_total += added;
      end
      random_total += phase_total;
      phase++;
      wait_idle();
    end

    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_fields.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
